// ===== src/colormap_pixel_compose_assert.svh =====
// assertion macros used by the colormap pixel compose rtl
`ifndef COLORMAP_PIXEL_COMPOSE_ASSERT_SVH
`define COLORMAP_PIXEL_COMPOSE_ASSERT_SVH

// checked only while out of reset
`define CMPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define CMPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/cmpc_pkg.sv =====
// types and constants of the colormap pixel compose block
package cmpc_pkg;

    localparam int STYLE_BITS = 12;
    localparam int TONE_BITS  = 8;
    localparam int ALPHA_BITS = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = STYLE_BITS;

    localparam logic [TONE_BITS-1:0] TONE_MAX = '1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_OPERATION      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STYLE_ID       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_ORDER     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOCK_ALPHA     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SELECTIVE      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SELECTED_STYLE = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ERASE_LINES    = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ERASE_AREAS    = 3'd7;

    // operation codes
    localparam logic OP_PAINT = 1'b0;
    localparam logic OP_ERASE = 1'b1;

    // draw order codes, the unused code behaves as palette order
    localparam logic [1:0] DRAW_OVER_ALL  = 2'd0;
    localparam logic [1:0] DRAW_UNDER_ALL = 2'd1;
    localparam logic [1:0] DRAW_PALETTE   = 2'd2;

    typedef struct packed {
        logic                  operation;
        logic [STYLE_BITS-1:0] style_id;
        logic [1:0]            draw_order;
        logic                  lock_alpha;
        logic                  selective;
        logic [STYLE_BITS-1:0] selected_style;
        logic                  erase_lines;
        logic                  erase_areas;
    } cmpc_cfg_t;

    typedef struct packed {
        logic [ALPHA_BITS-1:0] brush_alpha;
        logic [STYLE_BITS-1:0] dest_ink;
        logic [STYLE_BITS-1:0] dest_paint;
        logic [TONE_BITS-1:0]  dest_tone;
        logic                  ink_above;
    } cmpc_in_t;

    typedef struct packed {
        logic [STYLE_BITS-1:0] new_ink;
        logic [STYLE_BITS-1:0] new_paint;
        logic [TONE_BITS-1:0]  new_tone;
        logic                  written;
    } cmpc_out_t;

endpackage

// ===== src/cmpc_cfg_regs.sv =====
// configuration register file of the colormap pixel compose block
module cmpc_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cmpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [cmpc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output cmpc_pkg::cmpc_cfg_t                  cfg
);

    cmpc_pkg::cmpc_cfg_t cfg_reg;
    cmpc_pkg::cmpc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                cmpc_pkg::REG_OPERATION:      cfg_next.operation      = cfg_wdata[0];
                cmpc_pkg::REG_STYLE_ID:       cfg_next.style_id       = cfg_wdata;
                cmpc_pkg::REG_DRAW_ORDER:     cfg_next.draw_order     = cfg_wdata[1:0];
                cmpc_pkg::REG_LOCK_ALPHA:     cfg_next.lock_alpha     = cfg_wdata[0];
                cmpc_pkg::REG_SELECTIVE:      cfg_next.selective      = cfg_wdata[0];
                cmpc_pkg::REG_SELECTED_STYLE: cfg_next.selected_style = cfg_wdata;
                cmpc_pkg::REG_ERASE_LINES:    cfg_next.erase_lines    = cfg_wdata[0];
                cmpc_pkg::REG_ERASE_AREAS:    cfg_next.erase_areas    = cfg_wdata[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.operation      <= cmpc_pkg::OP_PAINT;
            cfg_reg.style_id       <= cmpc_pkg::STYLE_BITS'(1);
            cfg_reg.draw_order     <= cmpc_pkg::DRAW_OVER_ALL;
            cfg_reg.lock_alpha     <= 1'b0;
            cfg_reg.selective      <= 1'b0;
            cfg_reg.selected_style <= '0;
            cfg_reg.erase_lines    <= 1'b1;
            cfg_reg.erase_areas    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/cmpc_compose.sv =====
// combinational pixel compose for paint and erase strokes
module cmpc_compose (
    input  cmpc_pkg::cmpc_cfg_t cfg,
    input  cmpc_pkg::cmpc_in_t  pix,
    output cmpc_pkg::cmpc_out_t res
);

    localparam int PROD_BITS = 2 * cmpc_pkg::TONE_BITS;

    logic [cmpc_pkg::TONE_BITS-1:0] alpha_inv;
    logic                           same;
    logic                           tone_lt;
    logic                           tone_eq;
    logic                           keep_ink;
    logic                           lock_skip;
    logic [PROD_BITS-1:0]           prod;
    logic [PROD_BITS:0]             quot_sum;
    logic [cmpc_pkg::TONE_BITS-1:0] mul_tone;
    logic [cmpc_pkg::TONE_BITS-1:0] paint_tone;

    // coverage complement, 255 - alpha
    assign alpha_inv = cmpc_pkg::TONE_MAX - pix.brush_alpha;
    assign same      = (cfg.style_id == pix.dest_ink);
    assign tone_lt   = (pix.dest_tone < alpha_inv);
    assign tone_eq   = (pix.dest_tone == alpha_inv);

    // floor(prod / 255) as (prod + prod/256 + 1) / 256, exact for any product of two 8-bit values
    assign prod     = PROD_BITS'(pix.dest_tone) * PROD_BITS'(alpha_inv);
    assign quot_sum = (PROD_BITS+1)'(prod) + (PROD_BITS+1)'(prod >> cmpc_pkg::TONE_BITS)
                      + (PROD_BITS+1)'(1);
    assign mul_tone = quot_sum[cmpc_pkg::TONE_BITS +: cmpc_pkg::TONE_BITS];

    assign lock_skip = cfg.lock_alpha && (pix.dest_paint == '0)
                       && (pix.dest_tone == cmpc_pkg::TONE_MAX);

    always_comb begin
        paint_tone = same ? mul_tone : (tone_lt ? pix.dest_tone : alpha_inv);
        case (cfg.draw_order)
            cmpc_pkg::DRAW_OVER_ALL: begin
                if (cfg.lock_alpha) begin
                    paint_tone = pix.dest_tone;
                end
                keep_ink = tone_lt;
            end
            cmpc_pkg::DRAW_UNDER_ALL: begin
                keep_ink = tone_lt || tone_eq;
            end
            default: begin
                keep_ink = tone_lt || (tone_eq && pix.ink_above);
            end
        endcase
    end

    always_comb begin
        res.new_ink   = pix.dest_ink;
        res.new_paint = pix.dest_paint;
        res.new_tone  = pix.dest_tone;
        res.written   = 1'b0;
        if (pix.brush_alpha != '0) begin
            if (cfg.operation == cmpc_pkg::OP_ERASE) begin
                if (cfg.erase_areas
                        && (!cfg.selective || cfg.selected_style == pix.dest_paint)) begin
                    res.new_paint = '0;
                end
                if (cfg.erase_lines
                        && (!cfg.selective || cfg.selected_style == pix.dest_ink)) begin
                    res.new_tone = (pix.dest_tone > pix.brush_alpha) ? pix.dest_tone
                                                                     : pix.brush_alpha;
                end
                res.written = 1'b1;
            end else if (!lock_skip) begin
                res.new_tone = paint_tone;
                res.new_ink  = (!same && keep_ink) ? pix.dest_ink : cfg.style_id;
                res.written  = 1'b1;
            end
        end
    end

endmodule

// ===== src/colormap_pixel_compose.sv =====
// colormap pixel compose top level: config registers, input and result stages
// Takes one brush coverage value and one colormap pixel per item and returns the
// composed pixel. Throughput is one item per clock while the result side is not stalled.
// An item passes through one input register and one result register, with the
// compose logic (one 8x8 multiply and reciprocal correction) between them. A stalled
// result holds its register while the input register can still take one more item.
// Configuration registers may only be written while no item is in flight.
`include "colormap_pixel_compose_assert.svh"

module colormap_pixel_compose (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cmpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [cmpc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  cmpc_pkg::cmpc_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output cmpc_pkg::cmpc_out_t                  m_data
);

    cmpc_pkg::cmpc_cfg_t cfg;
    cmpc_pkg::cmpc_in_t  in_reg;
    cmpc_pkg::cmpc_out_t res;
    cmpc_pkg::cmpc_out_t out_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;

    cmpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cmpc_compose u_compose (
        .cfg (cfg),
        .pix (in_reg),
        .res (res)
    );

    // result register free or draining this cycle
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance && in_valid_reg) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `CMPC_ASSERT(a_full_stall_blocks_input,
        m_valid && !m_ready && in_valid_reg |-> !s_ready,
        "input taken while both stages are full")
    `CMPC_ASSERT(a_zero_alpha_untouched,
        in_valid_reg && advance && in_reg.brush_alpha == '0 |=> m_valid && !m_data.written,
        "zero coverage item marked written")
    `CMPC_ASSERT(a_erase_keeps_ink,
        in_valid_reg && advance && cfg.operation == cmpc_pkg::OP_ERASE
            |=> m_data.new_ink == $past(in_reg.dest_ink),
        "erase changed the ink style")
    `CMPC_ASSERT_ALWAYS(a_reset_empties_output, !aresetn |=> !m_valid,
        "result valid right after reset")

endmodule

// ===== dv/colormap_pixel_compose_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the colormap pixel compose block
module colormap_pixel_compose_test;

    // draw order code with no name of its own, acts as palette order
    localparam logic [1:0] DRAW_UNUSED = 2'd3;
    localparam cmpc_pkg::cmpc_cfg_t CFG_RESET = '{operation: cmpc_pkg::OP_PAINT,
        style_id: 12'd1, draw_order: cmpc_pkg::DRAW_OVER_ALL, lock_alpha: 1'b0,
        selective: 1'b0, selected_style: 12'd0, erase_lines: 1'b1, erase_areas: 1'b0};
    localparam int RX_HOLD_CYCLES = 64;
    localparam int IDLE_PERCENT = 18;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [cmpc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [cmpc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                                s_valid;
    logic                                s_ready;
    cmpc_pkg::cmpc_in_t                  s_data;
    logic                                m_valid;
    logic                                m_ready;
    cmpc_pkg::cmpc_out_t                 m_data;

    cmpc_pkg::cmpc_cfg_t cfg_shadow = CFG_RESET;
    cmpc_pkg::cmpc_out_t pixel_expect_q[$];
    int        mismatch_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_request = 1'b0;
    int        rx_hold_left = 0;

    colormap_pixel_compose u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic cmpc_pkg::cmpc_out_t compose_pixel(cmpc_pkg::cmpc_cfg_t cfg,
                                                          cmpc_pkg::cmpc_in_t px);
        cmpc_pkg::cmpc_out_t            res;
        logic [cmpc_pkg::TONE_BITS-1:0] inv_alpha;
        logic                           same_ink;
        logic                           keep_ink;
        logic                           hit_ink;
        logic                           hit_paint;
        logic [31:0]                    product;
        res = '{new_ink: px.dest_ink, new_paint: px.dest_paint,
                new_tone: px.dest_tone, written: 1'b0};
        if (px.brush_alpha == '0)
            return res;
        if (cfg.operation == cmpc_pkg::OP_ERASE) begin
            hit_ink   = !cfg.selective || cfg.selected_style == px.dest_ink;
            hit_paint = !cfg.selective || cfg.selected_style == px.dest_paint;
            if (cfg.erase_areas && hit_paint)
                res.new_paint = '0;
            if (cfg.erase_lines && hit_ink && px.brush_alpha > px.dest_tone)
                res.new_tone = px.brush_alpha;
            res.written = 1'b1;
            return res;
        end
        // lock-alpha leaves empty background alone
        if (cfg.lock_alpha && px.dest_paint == '0 && px.dest_tone == cmpc_pkg::TONE_MAX)
            return res;
        inv_alpha = cmpc_pkg::TONE_MAX - px.brush_alpha;
        same_ink  = cfg.style_id == px.dest_ink;
        product   = 32'(px.dest_tone) * 32'(inv_alpha);
        if (same_ink)
            res.new_tone = cmpc_pkg::TONE_BITS'(product / 255);
        else
            res.new_tone = (px.dest_tone < inv_alpha) ? px.dest_tone : inv_alpha;
        case (cfg.draw_order)
            cmpc_pkg::DRAW_OVER_ALL: begin
                if (cfg.lock_alpha)
                    res.new_tone = px.dest_tone;
                keep_ink = px.dest_tone < inv_alpha;
            end
            cmpc_pkg::DRAW_UNDER_ALL: keep_ink = px.dest_tone <= inv_alpha;
            default: keep_ink = px.dest_tone < inv_alpha ||
                                (px.dest_tone == inv_alpha && px.ink_above);
        endcase
        res.new_ink = (!same_ink && keep_ink) ? px.dest_ink : cfg.style_id;
        res.written = 1'b1;
        return res;
    endfunction

    function automatic cmpc_pkg::cmpc_in_t pix(logic [cmpc_pkg::ALPHA_BITS-1:0] alpha,
                                               logic [cmpc_pkg::STYLE_BITS-1:0] ink,
                                               logic [cmpc_pkg::STYLE_BITS-1:0] paint,
                                               logic [cmpc_pkg::TONE_BITS-1:0] tone,
                                               logic above);
        return '{brush_alpha: alpha, dest_ink: ink, dest_paint: paint,
                 dest_tone: tone, ink_above: above};
    endfunction

    // biased toward matching styles, tone boundaries and background pixels
    function automatic cmpc_pkg::cmpc_in_t rand_pixel();
        cmpc_pkg::cmpc_in_t px;
        case ($urandom_range(9))
            0: px.brush_alpha = '0;
            1: px.brush_alpha = '1;
            default: px.brush_alpha = 8'($urandom_range(255));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: px.dest_ink = cfg_shadow.style_id;
            4, 5: px.dest_ink = cfg_shadow.selected_style;
            default: px.dest_ink = 12'($urandom_range(4095));
        endcase
        case ($urandom_range(5))
            0: px.dest_paint = '0;
            1: px.dest_paint = cfg_shadow.selected_style;
            default: px.dest_paint = 12'($urandom_range(4095));
        endcase
        case ($urandom_range(7))
            0: px.dest_tone = cmpc_pkg::TONE_MAX;
            1, 2: px.dest_tone = cmpc_pkg::TONE_MAX - px.brush_alpha;
            3: px.dest_tone = '0;
            default: px.dest_tone = 8'($urandom_range(255));
        endcase
        px.ink_above = 1'($urandom_range(1));
        return px;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // keeps valid high back to back unless random idle gaps are on; finish_burst lowers it
    task automatic send_pixel(cmpc_pkg::cmpc_in_t px);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        pixel_expect_q.insert(pixel_expect_q.size(), compose_pixel(cfg_shadow, px));
    endtask

    task automatic finish_burst();
        s_valid <= 1'b0;
        while (pixel_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [cmpc_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [cmpc_pkg::CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(cmpc_pkg::cmpc_cfg_t cfg);
        finish_burst();
        write_reg(cmpc_pkg::REG_OPERATION, cmpc_pkg::CFG_DATA_BITS'(cfg.operation));
        write_reg(cmpc_pkg::REG_STYLE_ID, cfg.style_id);
        write_reg(cmpc_pkg::REG_DRAW_ORDER, cmpc_pkg::CFG_DATA_BITS'(cfg.draw_order));
        write_reg(cmpc_pkg::REG_LOCK_ALPHA, cmpc_pkg::CFG_DATA_BITS'(cfg.lock_alpha));
        write_reg(cmpc_pkg::REG_SELECTIVE, cmpc_pkg::CFG_DATA_BITS'(cfg.selective));
        write_reg(cmpc_pkg::REG_SELECTED_STYLE, cfg.selected_style);
        write_reg(cmpc_pkg::REG_ERASE_LINES, cmpc_pkg::CFG_DATA_BITS'(cfg.erase_lines));
        write_reg(cmpc_pkg::REG_ERASE_AREAS, cmpc_pkg::CFG_DATA_BITS'(cfg.erase_areas));
        cfg_wr_en <= 1'b0;
        cfg_shadow = cfg;
    endtask

    task automatic test_paint_cases();
        cmpc_pkg::cmpc_cfg_t cfg;
        // settings out of reset: style 1 over all
        send_pixel(pix(8'd0, 12'd1, 12'd5, 8'd100, 1'b0));
        send_pixel(pix(8'd255, 12'hFFF, 12'hFFF, 8'd255, 1'b1));
        send_pixel(pix(8'd1, 12'd1, 12'd0, 8'd255, 1'b0));
        send_pixel(pix(8'd128, 12'd7, 12'd3, 8'd127, 1'b0));
        send_pixel(pix(8'd128, 12'd7, 12'd3, 8'd126, 1'b1));
        cfg = CFG_RESET;
        cfg.lock_alpha = 1'b1;
        apply_cfg(cfg);
        send_pixel(pix(8'd200, 12'd0, 12'd0, 8'd255, 1'b0));
        send_pixel(pix(8'd200, 12'd9, 12'd4, 8'd30, 1'b0));
        cfg.draw_order = cmpc_pkg::DRAW_UNDER_ALL;
        apply_cfg(cfg);
        send_pixel(pix(8'd100, 12'd9, 12'd4, 8'd155, 1'b0));
        send_pixel(pix(8'd100, 12'd9, 12'd0, 8'd255, 1'b0));
        cfg.lock_alpha = 1'b0;
        cfg.draw_order = cmpc_pkg::DRAW_PALETTE;
        cfg.style_id   = 12'hFFF;
        apply_cfg(cfg);
        send_pixel(pix(8'd100, 12'd9, 12'd4, 8'd155, 1'b1));
        send_pixel(pix(8'd100, 12'd9, 12'd4, 8'd155, 1'b0));
        send_pixel(pix(8'd50, 12'hFFF, 12'd1, 8'd200, 1'b0));
        cfg.draw_order = DRAW_UNUSED;
        apply_cfg(cfg);
        send_pixel(pix(8'd100, 12'd9, 12'd4, 8'd155, 1'b1));
        send_pixel(pix(8'd100, 12'd9, 12'd4, 8'd155, 1'b0));
        finish_burst();
    endtask

    task automatic test_erase_cases();
        cmpc_pkg::cmpc_cfg_t cfg;
        cfg = CFG_RESET;
        cfg.operation = cmpc_pkg::OP_ERASE;
        apply_cfg(cfg);
        send_pixel(pix(8'd60, 12'd3, 12'd3, 8'd10, 1'b0));
        send_pixel(pix(8'd60, 12'd3, 12'd3, 8'd200, 1'b0));
        send_pixel(pix(8'd0, 12'd3, 12'd3, 8'd10, 1'b0));
        cfg.erase_areas    = 1'b1;
        cfg.selective      = 1'b1;
        cfg.selected_style = 12'd3;
        apply_cfg(cfg);
        send_pixel(pix(8'd60, 12'd3, 12'd3, 8'd10, 1'b0));
        send_pixel(pix(8'd60, 12'd4, 12'd3, 8'd10, 1'b0));
        send_pixel(pix(8'd60, 12'd3, 12'd4, 8'd10, 1'b0));
        cfg.erase_lines = 1'b0;
        cfg.selective   = 1'b0;
        apply_cfg(cfg);
        send_pixel(pix(8'd255, 12'hFFF, 12'hFFF, 8'd0, 1'b1));
        finish_burst();
    endtask

    // result side stops for a long stretch so the block backs up into its input
    task automatic test_result_backpressure();
        idle_on      = 1'b0;
        hold_request = 1'b1;
        repeat (60) send_pixel(rand_pixel());
        finish_burst();
        idle_on = 1'b1;
    endtask

    task automatic test_random_pixels();
        cmpc_pkg::cmpc_cfg_t cfg;
        for (int phase_no = 0; phase_no < 13; phase_no++) begin
            if (phase_no == 0) begin
                cfg = '0;
            end else if (phase_no == 1) begin
                cfg = '1;
            end else begin
                cfg.operation      = 1'($urandom_range(1));
                cfg.style_id       = ($urandom_range(3) == 0) ? '1 : 12'($urandom_range(4095));
                cfg.draw_order     = 2'($urandom_range(3));
                cfg.lock_alpha     = 1'($urandom_range(1));
                cfg.selective      = 1'($urandom_range(1));
                cfg.selected_style = ($urandom_range(3) == 0) ? '0 : 12'($urandom_range(4095));
                cfg.erase_lines    = 1'($urandom_range(1));
                cfg.erase_areas    = 1'($urandom_range(1));
            end
            apply_cfg(cfg);
            idle_on = (phase_no != 5);
            repeat (100) send_pixel(rand_pixel());
        end
        finish_burst();
        idle_on = 1'b1;
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_left == 0 && hold_request) begin
                hold_request = 1'b0;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_on || $urandom_range(99) >= IDLE_PERCENT;
            end
        end
    end

    always @(posedge aclk) begin
        cmpc_pkg::cmpc_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pixel_expect_q.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_data.new_ink), 0);
            end else begin
                want = pixel_expect_q.pop_front();
                if (m_data.new_ink !== want.new_ink)
                    report_mismatch("new_ink", 32'(m_data.new_ink), 32'(want.new_ink));
                if (m_data.new_paint !== want.new_paint)
                    report_mismatch("new_paint", 32'(m_data.new_paint), 32'(want.new_paint));
                if (m_data.new_tone !== want.new_tone)
                    report_mismatch("new_tone", 32'(m_data.new_tone), 32'(want.new_tone));
                if (m_data.written !== want.written)
                    report_mismatch("written", 32'(m_data.written), 32'(want.written));
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_paint_cases();
        test_erase_cases();
        test_result_backpressure();
        test_random_pixels();
        repeat (8) @(posedge aclk);
        if (pixel_expect_q.size() != 0)
            report_mismatch("results missing", 32'(pixel_expect_q.size()), 0);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/cmpc_pkg.sv
src/cmpc_cfg_regs.sv
src/cmpc_compose.sv
src/colormap_pixel_compose.sv
dv/colormap_pixel_compose_test.sv
